// ===== rtl/core/srgb_mse_pkg.sv =====
`default_nettype none

package srgb_mse_pkg;

  // Fixed point and sizing
  localparam int LINEAR_BITS = 16;
  localparam int LIN_W       = LINEAR_BITS + 1;
  localparam int MAX_PIXELS  = 4194304;
  localparam int CNT_W       = 23;
  localparam int PIX_W       = 24;
  localparam int CODE_W      = 8;
  localparam int SQ_W        = 2 * LINEAR_BITS + 1;
  localparam int SUM_W       = 58;
  localparam int NUM_W       = SUM_W + 1;
  localparam int DEN_W       = CNT_W + 2;
  localparam int MSE_W       = 33;
  localparam int STEP_W      = $clog2(NUM_W + 1);
  localparam logic [63:0] MSE_MAX = 64'h1_0000_0000;

  // Width for the exact table build: den^12 times (2e-1)^5
  localparam int BIG_W = 12 * 19 + 5 * (LINEAR_BITS + 2) + 8;

  // Channel select codes
  typedef logic [1:0] chan_sel_t;
  localparam chan_sel_t CH_RED   = 2'd0;
  localparam chan_sel_t CH_GREEN = 2'd1;
  localparam chan_sel_t CH_BLUE  = 2'd2;

  // Sequencer to channel unit
  typedef struct packed {
    logic      load_diff;
    logic      load_sq;
    chan_sel_t sel;
  } chan_ctl_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  // sRGB-to-linear table, evaluated at elaboration with exact integer math.
  // Low segment: round(2^L * k / (255 * 12.92)).
  // Curve: largest e with (2e-1)^5 * den^12 <= 2^(5L+5) * a^12.
  function automatic logic [LIN_W*256-1:0] build_lin_table();
    logic [LIN_W*256-1:0] tab;
    logic [BIG_W-1:0]     bpow;
    logic [BIG_W-1:0]     rhs;
    logic [BIG_W-1:0]     lhs;
    logic [63:0]          num;
    logic [31:0]          a;
    logic [31:0]          lo;
    logic [31:0]          hi;
    logic [31:0]          mid;
    int                   i;
    int                   k;
    tab  = '0;
    bpow = BIG_W'(1);
    for (i = 0; i < 12; i++) begin
      bpow = bpow * BIG_W'(269025);
    end
    for (k = 0; k < 256; k++) begin
      if (k <= 10) begin
        num = (64'(k) * 64'd100) << LINEAR_BITS;
        tab[k*LIN_W +: LIN_W] = LIN_W'((num + 64'd164730) / 64'd329460);
      end else begin
        a   = 32'(k) * 32'd1000 + 32'd14025;
        rhs = BIG_W'(1);
        for (i = 0; i < 12; i++) begin
          rhs = rhs * BIG_W'(a);
        end
        rhs = rhs << (5 * LINEAR_BITS + 5);
        lo  = 32'd1;
        hi  = (32'd1 << LINEAR_BITS) + 32'd1;
        while (hi - lo > 32'd1) begin
          mid = lo + ((hi - lo) >> 1);
          lhs = bpow;
          for (i = 0; i < 5; i++) begin
            lhs = lhs * BIG_W'(2 * mid - 32'd1);
          end
          if (lhs <= rhs) begin
            lo = mid;
          end else begin
            hi = mid;
          end
        end
        tab[k*LIN_W +: LIN_W] = LIN_W'(lo);
      end
    end
    return tab;
  endfunction

  localparam logic [LIN_W*256-1:0] LIN_TABLE = build_lin_table();

  function automatic logic [LIN_W-1:0] lin_lookup(input logic [CODE_W-1:0] code);
    return LIN_TABLE[code*LIN_W +: LIN_W];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/srgb_mse_pair_if.sv =====
`default_nettype none

interface srgb_mse_pair_if
  import srgb_mse_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] ref_pixel;
  logic [PIX_W-1:0] test_pixel;
  logic             last;

  modport source (output valid, ref_pixel, test_pixel, last, input ready);
  modport sink   (input valid, ref_pixel, test_pixel, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/srgb_mse_res_if.sv =====
`default_nettype none

interface srgb_mse_res_if
  import srgb_mse_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [MSE_W-1:0] mse;
  logic [CNT_W-1:0] pixels_seen;
  logic             count_overflow;

  modport source (output valid, mse, pixels_seen, count_overflow, input ready);
  modport sink   (input valid, mse, pixels_seen, count_overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/srgb_mse_chan.sv =====
`default_nettype none

// Shared channel unit: table lookup and difference, then one squaring
module srgb_mse_chan
  import srgb_mse_pkg::*;
(
  input  logic             clk,
  input  chan_ctl_t        ctl,
  input  logic [PIX_W-1:0] ref_pixel,
  input  logic [PIX_W-1:0] test_pixel,
  output logic [SQ_W-1:0]  sq
);

  logic [CODE_W-1:0]  ref_code;
  logic [CODE_W-1:0]  test_code;
  logic [LIN_W-1:0]   ref_lin;
  logic [LIN_W-1:0]   test_lin;
  logic [LIN_W-1:0]   diff_in;
  logic [LIN_W-1:0]   diff;
  logic [2*LIN_W-1:0] prod;

  // Pick the channel bytes
  always_comb begin
    case (ctl.sel)
      CH_RED: begin
        ref_code  = ref_pixel[23:16];
        test_code = test_pixel[23:16];
      end
      CH_GREEN: begin
        ref_code  = ref_pixel[15:8];
        test_code = test_pixel[15:8];
      end
      default: begin
        ref_code  = ref_pixel[7:0];
        test_code = test_pixel[7:0];
      end
    endcase
  end

  // Linearize and take the magnitude of the difference
  assign ref_lin  = lin_lookup(ref_code);
  assign test_lin = lin_lookup(test_code);
  assign diff_in  = (ref_lin > test_lin) ? (ref_lin - test_lin) : (test_lin - ref_lin);

  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    if (ctl.load_diff) begin
      diff <= diff_in;
    end
    if (ctl.load_sq) begin
      sq <= prod[SQ_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/srgb_mse_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first
module srgb_mse_div
  import srgb_mse_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  den;
  logic [STEP_W-1:0] steps;
  logic              active;
  logic              done;
  logic [DEN_W:0]    trial;
  logic              fits;

  // Trial subtract of the next partial remainder
  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      steps  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        steps  <= STEP_W'(NUM_W);
      end else if (active) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Datapath: numerator shifts out the top while quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (active) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule

`default_nettype wire

// ===== rtl/core/srgb_linear_image_mse.sv =====
// Sequencing: an ordinary pair goes through 3 channels x lookup, square,
// accumulate, through one shared channel unit; the next pair is taken after that.
// A pair arriving with the count full is not accumulated; it only sets the
// overflow flag. The last pair adds the bit-serial division before the result
// appears. Reset clears the sum, count and flag.
`default_nettype none

module srgb_linear_image_mse
  import srgb_mse_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  srgb_mse_pair_if.sink   pix,
  srgb_mse_res_if.source  res
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIFF  = 6'b000010,
    S_MUL   = 6'b000100,
    S_ACC   = 6'b001000,
    S_START = 6'b010000,
    S_DIV   = 6'b100000
  } state_t;

  state_t           state;
  logic             wait_out;
  chan_sel_t        ch;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic             last_q;
  logic [PIX_W-1:0] ref_q;
  logic [PIX_W-1:0] test_q;

  logic             out_valid;
  logic [MSE_W-1:0] mse_q;
  logic [CNT_W-1:0] seen_q;
  logic             ovf_q;

  logic             accepted;
  logic             out_free;
  logic             out_load;
  chan_ctl_t        chan_ctl;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic [SQ_W-1:0]  sq;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_sat;
  logic [DEN_W-1:0] den3;
  logic [MSE_W-1:0] mse_clamp;

  assign pix.ready = (state == S_IDLE) && !wait_out;
  assign accepted  = pix.valid && pix.ready;
  assign out_free  = !out_valid || res.ready;
  assign out_load  = wait_out && out_free;

  // Channel unit control
  assign chan_ctl.load_diff = (state == S_DIFF);
  assign chan_ctl.load_sq   = (state == S_MUL);
  assign chan_ctl.sel       = ch;

  srgb_mse_chan u_chan (
    .clk        (clk),
    .ctl        (chan_ctl),
    .ref_pixel  (ref_q),
    .test_pixel (test_q),
    .sq         (sq)
  );

  // Saturating accumulate
  assign sum_add = {1'b0, sum} + (SUM_W + 1)'(sq);
  assign sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

  // Rounded mean: (sum + 3n/2) / 3n
  assign den3           = DEN_W'({count, 1'b0}) + DEN_W'(count);
  assign div_req.start  = (state == S_START);
  assign div_req.num    = {1'b0, sum} + NUM_W'(den3 >> 1);
  assign div_req.den    = den3;

  srgb_mse_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign mse_clamp = (div_rsp.quot > NUM_W'(MSE_MAX)) ? MSE_W'(MSE_MAX)
                                                      : div_rsp.quot[MSE_W-1:0];

  // Sequencer and accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wait_out  <= 1'b0;
      ch        <= CH_RED;
      sum       <= '0;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        wait_out  <= 1'b0;
        sum       <= '0;
        count     <= '0;
        ovf       <= 1'b0;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accepted) begin
            if (count == CNT_W'(MAX_PIXELS)) begin
              ovf <= 1'b1;
              if (pix.last) begin
                state <= S_START;
              end
            end else begin
              count <= count + CNT_W'(1);
              ch    <= CH_RED;
              state <= S_DIFF;
            end
          end
        end
        S_DIFF: state <= S_MUL;
        S_MUL:  state <= S_ACC;
        S_ACC: begin
          sum <= sum_sat;
          if (ch == CH_BLUE) begin
            state <= last_q ? S_START : S_IDLE;
          end else begin
            ch    <= (ch == CH_RED) ? CH_GREEN : CH_BLUE;
            state <= S_DIFF;
          end
        end
        S_START: state <= S_DIV;
        S_DIV: begin
          if (div_rsp.done) begin
            wait_out <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Input beat capture
  always_ff @(posedge clk) begin
    if (accepted) begin
      ref_q  <= pix.ref_pixel;
      test_q <= pix.test_pixel;
      last_q <= pix.last;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      mse_q  <= mse_clamp;
      seen_q <= count;
      ovf_q  <= ovf;
    end
  end

  assign res.valid          = out_valid;
  assign res.mse            = mse_q;
  assign res.pixels_seen    = seen_q;
  assign res.count_overflow = ovf_q;

endmodule

`default_nettype wire
